// ===== sv/wspm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard star pattern matcher package
// Item kinds, status codes, special pattern bytes and the control bundle
// that the top level broadcasts to every matcher cell.
// ----------------------------------------------------------------------------
package wspm_pkg;

	// Kind of an input item.
	typedef enum logic [1:0] {
		K_APPEND  = 2'd0,
		K_SUBJECT = 2'd1,
		K_END     = 2'd2,
		K_CLEAR   = 2'd3
	} kind_t;

	// Status reported with each match result.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_LEAD_STAR = 2'd2
	} status_t;

	// Special pattern bytes.
	localparam logic [7:0] DOT_BYTE  = 8'h2E;
	localparam logic [7:0] STAR_BYTE = 8'h2A;

	// Per-cycle command broadcast to the row of cells.
	typedef struct packed {
		logic clr;      // empty the pattern
		logic wr;       // store a pattern byte (cell at the fill point)
		logic restart;  // reload the live row from the empty-subject row
		logic sub;      // advance the live row by one subject byte
	} cell_ctl_t;

endpackage

// ===== sv/wildcard_star_pattern_matcher_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard star pattern matcher core
// Whole-string matching of a subject against a pattern with '.' and '*',
// kept as a row of cells that each own one pattern position.
// ----------------------------------------------------------------------------
// Channel  Signals                       Direction  Transfer
// in       in_valid/in_ready kind symbol  input      one item per transfer
// out      out_valid/out_ready matched    output     one result per end item
//          status
//
// A subject byte updates all cells at once, the star terms rippling
// combinationally along the row.
// Only end items produce a result, held in one output register.
// A new item is taken while the output register is empty or being drained.
// Reset empties the pattern; the row comes up with only position zero live.
// ----------------------------------------------------------------------------
module wildcard_star_pattern_matcher_core #(
	parameter int MAX_PATTERN = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  wspm_pkg::kind_t   kind,
	input  logic [7:0]        symbol,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              matched,
	output wspm_pkg::status_t status
);
	import wspm_pkg::*;

	localparam int CNT_W = $clog2(MAX_PATTERN + 1);

	logic                 in_xfer;
	logic                 full;
	logic [CNT_W-1:0]     count_q;
	logic                 live0_q;
	logic                 ovf_q;
	logic                 lead_q;
	logic                 out_valid_q;
	logic                 matched_q;
	status_t              status_q;
	status_t              cur_status;
	cell_ctl_t            ctl;
	logic [MAX_PATTERN:0] next_v;
	logic [MAX_PATTERN:0] live_v;
	logic [MAX_PATTERN:0] empty_v;
	logic [7:0]           pat_v [0:MAX_PATTERN];

	// Input transfer and commands to the cells.
	assign in_ready    = !out_valid_q || out_ready;
	assign in_xfer     = in_valid && in_ready;
	assign full        = (count_q == CNT_W'(MAX_PATTERN));
	assign ctl.clr     = in_xfer && (kind == K_CLEAR);
	assign ctl.wr      = in_xfer && (kind == K_APPEND) && !full;
	assign ctl.restart = in_xfer && ((kind == K_APPEND) || (kind == K_END));
	assign ctl.sub     = in_xfer && (kind == K_SUBJECT);

	// Position zero of the row: the empty prefix.
	assign next_v[0]  = 1'b0;
	assign live_v[0]  = live0_q;
	assign empty_v[0] = 1'b1;
	assign pat_v[0]   = 8'h00;

	// Row of cells, one per pattern position.
	for (genvar j = 1; j <= MAX_PATTERN; j++) begin : g_cell
		localparam int M2 = (j >= 2) ? (j - 2) : 0;
		wspm_cell #(
			.IDX   (j),
			.CNT_W (CNT_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.sym      (symbol),
			.count    (count_q),
			.next_m2  (next_v[M2]),
			.live_m1  (live_v[j-1]),
			.pat_m1   (pat_v[j-1]),
			.empty_m2 (empty_v[M2]),
			.next_o   (next_v[j]),
			.live_o   (live_v[j]),
			.pat_o    (pat_v[j]),
			.empty_o  (empty_v[j])
		);
	end

	// Fill count, fault flags and the empty-prefix bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			live0_q <= 1'b1;
			ovf_q   <= 1'b0;
			lead_q  <= 1'b0;
		end else if (ctl.clr) begin
			count_q <= '0;
			live0_q <= 1'b1;
			ovf_q   <= 1'b0;
			lead_q  <= 1'b0;
		end else begin
			if (ctl.wr) begin
				count_q <= count_q + CNT_W'(1);
				if ((count_q == '0) && (symbol == STAR_BYTE)) begin
					lead_q <= 1'b1;
				end
			end
			if (in_xfer && (kind == K_APPEND) && full) begin
				ovf_q <= 1'b1;
			end
			if (ctl.restart) begin
				live0_q <= 1'b1;
			end else if (ctl.sub) begin
				live0_q <= 1'b0;
			end
		end
	end

	// Status of the loaded pattern; overflow wins over a leading star.
	always_comb begin
		if (ovf_q) begin
			cur_status = ST_OVERFLOW;
		end else if (lead_q) begin
			cur_status = ST_LEAD_STAR;
		end else begin
			cur_status = ST_OK;
		end
	end

	// Output register for the match result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer && (kind == K_END)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && (kind == K_END)) begin
			matched_q <= (cur_status == ST_OK) && live_v[count_q];
			status_q  <= cur_status;
		end
	end

	assign out_valid = out_valid_q;
	assign matched   = matched_q;
	assign status    = status_q;

`ifndef SYNTHESIS
	// The fill count never passes the number of cells.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_PATTERN))
		else $error("pattern count beyond store depth");

	// A reported match always comes with a clean status.
	a_match_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && matched |-> status == ST_OK)
		else $error("match reported with fault status");

	// A clear empties the pattern on the next cycle.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && kind == K_CLEAR |=> count_q == '0 && !ovf_q && !lead_q)
		else $error("clear did not empty the pattern");

	// An end item always leaves a result in the output register.
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && kind == K_END |=> out_valid)
		else $error("end item produced no result");

	// After a subject byte the empty prefix can no longer match.
	a_live0: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.sub |=> !live0_q)
		else $error("empty prefix still live after subject byte");
`endif

endmodule

// ===== sv/wspm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard star pattern matcher cell
// One pattern position: holds its pattern byte, its live-row bit and its
// empty-subject bit, and computes its next live bit from its neighbors.
// ----------------------------------------------------------------------------
module wspm_cell #(
	parameter int IDX   = 1,
	parameter int CNT_W = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wspm_pkg::cell_ctl_t ctl,
	input  logic [7:0]          sym,
	input  logic [CNT_W-1:0]    count,
	input  logic                next_m2,
	input  logic                live_m1,
	input  logic [7:0]          pat_m1,
	input  logic                empty_m2,
	output logic                next_o,
	output logic                live_o,
	output logic [7:0]          pat_o,
	output logic                empty_o
);
	import wspm_pkg::*;

	logic       act_q;
	logic       live_q;
	logic       empty_q;
	logic [7:0] pat_q;
	logic       hit_own;
	logic       hit_m1;
	logic       is_star;
	logic       wr_here;
	logic       new_empty;

	// Element tests against the current subject byte.
	assign hit_own = (pat_q == DOT_BYTE) || (pat_q == sym);
	assign hit_m1  = (pat_m1 == DOT_BYTE) || (pat_m1 == sym);
	assign is_star = (pat_q == STAR_BYTE);

	// Next live bit; a star chains through the bit two cells back.
	always_comb begin
		if (!act_q) begin
			next_o = 1'b0;
		end else if (is_star) begin
			next_o = (IDX >= 2) ? (next_m2 | (hit_m1 & live_q)) : 1'b0;
		end else begin
			next_o = hit_own & live_m1;
		end
	end

	// This cell takes the byte when the fill point reaches it.
	assign wr_here   = ctl.wr && (count == CNT_W'(IDX - 1));
	assign new_empty = (sym == STAR_BYTE) && (IDX >= 2) && empty_m2;

	// Control and row state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= 1'b0;
			live_q  <= 1'b0;
			empty_q <= 1'b0;
		end else if (ctl.clr) begin
			act_q   <= 1'b0;
			live_q  <= 1'b0;
			empty_q <= 1'b0;
		end else if (wr_here) begin
			act_q   <= 1'b1;
			live_q  <= new_empty;
			empty_q <= new_empty;
		end else if (ctl.restart) begin
			live_q <= empty_q;
		end else if (ctl.sub) begin
			live_q <= next_o;
		end
	end

	// Pattern byte storage.
	always_ff @(posedge clk) begin
		if (wr_here) begin
			pat_q <= sym;
		end
	end

	assign live_o  = live_q;
	assign pat_o   = pat_q;
	assign empty_o = empty_q;

endmodule

// ===== bench/tb_wildcard_star_pattern_matcher_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the wildcard star pattern matcher core
// Loads patterns built from literal bytes, '.' and '*', streams subjects
// through the block and checks every end-of-subject result against a
// bit-parallel row predictor kept in step with the accepted input items.
// A short directed table comes first, then random pattern and subject
// sequences under three mixes of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_wildcard_star_pattern_matcher_core;
	import wspm_pkg::*;

	localparam int MAX_PAT       = 32;
	localparam int CLK_HALF      = 6;
	localparam int RAND_PER_MIX  = 420;
	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 10;
	localparam int REPORT_LIMIT  = 10;
	localparam int NUM_DIR       = 37;
	localparam logic [7:0] CH_A  = 8'h61;
	localparam logic [7:0] CH_B  = 8'h62;
	localparam logic [7:0] CH_X  = 8'h78;
	localparam logic [7:0] CH_Y  = 8'h79;

	// One match report as it leaves the block.
	typedef struct packed {
		logic    matched;
		status_t status;
	} match_res_t;

	// One row of the directed table; a typed row carries its own expectation.
	typedef struct packed {
		kind_t      k;
		logic [7:0] sym;
		logic [5:0] reps;
		logic       typed;
		match_res_t res;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	kind_t      kind = K_CLEAR;
	logic [7:0] symbol = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       matched;
	status_t    status;

	// Predictor state: stored pattern, empty-subject row and live row.
	logic [7:0]       pat_mem [MAX_PAT];
	int unsigned      pat_len;
	logic [MAX_PAT:0] empty_row;
	logic [MAX_PAT:0] live_row;
	bit               ovf_flag;
	bit               lead_flag;

	match_res_t  match_q [$];
	logic [7:0]  pat_q [$];
	logic [7:0]  subj_q [$];
	stim_row_t   dir_tab [NUM_DIR];

	int unsigned snd_idle_pct = 10;
	int unsigned rcv_idle_pct = 45;
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned full_matches = 0;
	int unsigned ovf_reports = 0;
	int unsigned star_reports = 0;
	int unsigned err_count = 0;
	int unsigned stall_cycles = 0;

	wildcard_star_pattern_matcher_core #(
		.MAX_PATTERN(MAX_PAT)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.symbol   (symbol),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.matched  (matched),
		.status   (status)
	);

	// Free-running clock.
	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// A pattern element accepts a subject byte when it is a dot or equal.
	function automatic bit elem_accepts(input logic [7:0] e, input logic [7:0] c);
		return (e == DOT_BYTE) || (e == c);
	endfunction

	// Empty the pattern, drop both faults and restart the subject.
	function automatic void pred_clear();
		pat_len   = 0;
		empty_row = '0;
		empty_row[0] = 1'b1;
		ovf_flag  = 1'b0;
		lead_flag = 1'b0;
		live_row  = empty_row;
	endfunction

	// Apply one accepted item to the predictor; returns 1 when it gives a report.
	function automatic bit pred_apply(input kind_t k, input logic [7:0] s,
			output match_res_t r);
		logic [MAX_PAT:0] nxt;
		logic             v;
		status_t          st;
		r = '0;
		case (k)
			K_APPEND: begin
				if (pat_len >= MAX_PAT) begin
					ovf_flag = 1'b1;
				end else begin
					if (pat_len == 0 && s == STAR_BYTE)
						lead_flag = 1'b1;
					pat_mem[pat_len] = s;
					pat_len++;
					if (s == STAR_BYTE && pat_len >= 2)
						empty_row[pat_len] = empty_row[pat_len - 2];
					else
						empty_row[pat_len] = 1'b0;
				end
				live_row = empty_row;
				return 1'b0;
			end
			K_SUBJECT: begin
				nxt = '0;
				for (int j = 1; j <= pat_len; j++) begin
					if (pat_mem[j - 1] == STAR_BYTE) begin
						// Star: skip the pair, or take one more copy of its element.
						v = 1'b0;
						if (j >= 2) begin
							v = nxt[j - 2];
							if (elem_accepts(pat_mem[j - 2], s) && live_row[j])
								v = 1'b1;
						end
						nxt[j] = v;
					end else begin
						nxt[j] = elem_accepts(pat_mem[j - 1], s) && live_row[j - 1];
					end
				end
				live_row = nxt;
				return 1'b0;
			end
			K_CLEAR: begin
				pred_clear();
				return 1'b0;
			end
			default: begin
				st = ovf_flag ? ST_OVERFLOW : (lead_flag ? ST_LEAD_STAR : ST_OK);
				r.matched = (st == ST_OK) && live_row[pat_len];
				r.status  = st;
				live_row  = empty_row;
				return 1'b1;
			end
		endcase
	endfunction

	// Offer one item, with random idle cycles ahead of it, until the transfer.
	task automatic send_item(input kind_t k, input logic [7:0] s,
			input bit use_typed, input match_res_t typed_res);
		match_res_t r;
		bit         has_res;
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		symbol   <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		has_res = pred_apply(k, s, r);
		if (has_res)
			match_q.push_back(use_typed ? typed_res : r);
	endtask

	task automatic send_plain(input kind_t k, input logic [7:0] s);
		send_item(k, s, 1'b0, '0);
	endtask

	// Pattern byte drawn mostly from a small alphabet so that subjects can hit.
	function automatic logic [7:0] pick_pat_byte(input bit first);
		int unsigned p;
		p = $urandom_range(99);
		if (first)
			return (p < 5) ? STAR_BYTE : ((p < 25) ? DOT_BYTE : (p < 60 ? CH_A : CH_B));
		if (p < 25)
			return CH_A;
		if (p < 40)
			return CH_B;
		if (p < 60)
			return DOT_BYTE;
		if (p < 85)
			return STAR_BYTE;
		return 8'($urandom_range(255));
	endfunction

	// Random pattern: mostly short, sometimes up to the store size, rarely past it.
	task automatic make_pattern();
		int unsigned n;
		int unsigned p;
		p = $urandom_range(99);
		if (p < 85)
			n = $urandom_range(0, 7);
		else if (p < 96)
			n = $urandom_range(8, MAX_PAT);
		else
			n = $urandom_range(MAX_PAT + 1, MAX_PAT + 4);
		pat_q.delete();
		for (int i = 0; i < n; i++)
			pat_q.push_back(pick_pat_byte(i == 0));
	endtask

	// Expand the pattern into a subject that should match, then maybe spoil it.
	task automatic make_subject();
		int unsigned i;
		int unsigned idx;
		logic [7:0]  e;
		subj_q.delete();
		i = 0;
		while (i < pat_q.size()) begin
			e = pat_q[i];
			if (e == STAR_BYTE && i == 0) begin
				i++;
			end else if (i + 1 < pat_q.size() && pat_q[i + 1] == STAR_BYTE) begin
				repeat ($urandom_range(0, 3))
					subj_q.push_back(e == DOT_BYTE ? 8'($urandom_range(255)) : e);
				i += 2;
			end else begin
				subj_q.push_back(e == DOT_BYTE ? 8'($urandom_range(255)) : e);
				i++;
			end
		end
		if ($urandom_range(3) == 0) begin
			if (subj_q.size() != 0 && $urandom_range(1) == 0) begin
				idx = $urandom_range(subj_q.size() - 1);
				if ($urandom_range(1) == 0)
					subj_q.delete(idx);
				else
					subj_q[idx] = $urandom_range(1) ? CH_A : 8'($urandom_range(255));
			end else begin
				subj_q.push_back($urandom_range(1) ? CH_B : 8'($urandom_range(255)));
			end
		end
	endtask

	// One well-formed sequence: clear, load, then a few subjects each closed by an end.
	task automatic send_sequence();
		send_plain(K_CLEAR, 8'($urandom_range(255)));
		make_pattern();
		foreach (pat_q[i])
			send_plain(K_APPEND, pat_q[i]);
		repeat ($urandom_range(1, 4)) begin
			make_subject();
			foreach (subj_q[i]) begin
				send_plain(K_SUBJECT, subj_q[i]);
				// Now and then the pattern grows under a subject in progress.
				if ($urandom_range(29) == 0)
					send_plain(K_APPEND, pick_pat_byte(1'b0));
			end
			send_plain(K_END, 8'($urandom_range(255)));
		end
	endtask

	// Receiver stalls at random.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	// Compare each report with the oldest expectation.
	always @(posedge clk) begin
		match_res_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (matched === 1'b1)
				full_matches++;
			if (status === ST_OVERFLOW)
				ovf_reports++;
			if (status === ST_LEAD_STAR)
				star_reports++;
			if (match_q.size() == 0) begin
				err_count++;
				if (err_count <= REPORT_LIMIT)
					$display("unexpected report: matched=%0b status=%0d", matched, status);
			end else begin
				want = match_q.pop_front();
				if (matched !== want.matched || status !== want.status) begin
					err_count++;
					if (err_count <= REPORT_LIMIT)
						$display("mismatch: expected %0b/%0d, got %0b/%0d (matched/status)",
							want.matched, want.status, matched, status);
				end
			end
		end
	end

	// Watchdog on cycles in which no transfer happens on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d cycles without a transfer", STALL_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Directed table: field extremes, every kind and each special case.
	initial begin
		dir_tab = '{
			// empty pattern against an empty subject
			'{K_END,     8'hFF,     6'd1,  1'b1, '{1'b1, ST_OK}},
			'{K_SUBJECT, CH_A,      6'd1,  1'b0, '0},
			'{K_END,     8'h00,     6'd1,  1'b1, '{1'b0, ST_OK}},
			// leading star
			'{K_APPEND,  STAR_BYTE, 6'd1,  1'b0, '0},
			'{K_END,     8'h00,     6'd1,  1'b1, '{1'b0, ST_LEAD_STAR}},
			'{K_CLEAR,   8'hFF,     6'd1,  1'b0, '0},
			// byte extremes with a star and a dot
			'{K_APPEND,  8'h00,     6'd1,  1'b0, '0},
			'{K_APPEND,  STAR_BYTE, 6'd1,  1'b0, '0},
			'{K_APPEND,  8'hFF,     6'd1,  1'b0, '0},
			'{K_APPEND,  DOT_BYTE,  6'd1,  1'b0, '0},
			'{K_SUBJECT, 8'h00,     6'd2,  1'b0, '0},
			'{K_SUBJECT, 8'hFF,     6'd1,  1'b0, '0},
			'{K_SUBJECT, 8'h80,     6'd1,  1'b0, '0},
			'{K_END,     8'h00,     6'd1,  1'b0, '0},
			'{K_END,     8'h00,     6'd1,  1'b0, '0},
			'{K_CLEAR,   8'h00,     6'd1,  1'b0, '0},
			// star after star takes a literal star as its element
			'{K_APPEND,  CH_X,      6'd1,  1'b0, '0},
			'{K_APPEND,  STAR_BYTE, 6'd2,  1'b0, '0},
			'{K_SUBJECT, CH_X,      6'd1,  1'b0, '0},
			'{K_SUBJECT, STAR_BYTE, 6'd1,  1'b0, '0},
			'{K_END,     8'h00,     6'd1,  1'b0, '0},
			// pattern grows in the middle of a subject
			'{K_SUBJECT, CH_X,      6'd1,  1'b0, '0},
			'{K_APPEND,  CH_Y,      6'd1,  1'b0, '0},
			'{K_SUBJECT, CH_X,      6'd1,  1'b0, '0},
			'{K_SUBJECT, CH_Y,      6'd1,  1'b0, '0},
			'{K_END,     8'h00,     6'd1,  1'b0, '0},
			// full store, then one byte too many
			'{K_CLEAR,   8'h00,     6'd1,  1'b0, '0},
			'{K_APPEND,  CH_B,      6'd32, 1'b0, '0},
			'{K_SUBJECT, CH_B,      6'd32, 1'b0, '0},
			'{K_END,     8'h00,     6'd1,  1'b1, '{1'b1, ST_OK}},
			'{K_APPEND,  CH_B,      6'd1,  1'b0, '0},
			'{K_END,     8'h00,     6'd1,  1'b1, '{1'b0, ST_OVERFLOW}},
			// both faults: overflow wins over the leading star
			'{K_CLEAR,   8'h00,     6'd1,  1'b0, '0},
			'{K_APPEND,  STAR_BYTE, 6'd33, 1'b0, '0},
			'{K_END,     8'h00,     6'd1,  1'b1, '{1'b0, ST_OVERFLOW}},
			// clear drops both faults
			'{K_CLEAR,   8'h00,     6'd1,  1'b0, '0},
			'{K_END,     8'h00,     6'd1,  1'b1, '{1'b1, ST_OK}}
		};
	end

	// Main sequence: reset, directed table, random mixes, drain and verdict.
	initial begin
		pred_clear();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[r])
			repeat (dir_tab[r].reps)
				send_item(dir_tab[r].k, dir_tab[r].sym, dir_tab[r].typed, dir_tab[r].res);

		for (int mix = 0; mix < 3; mix++) begin
			int unsigned mix_start;
			case (mix)
				0: begin
					snd_idle_pct = 10;
					rcv_idle_pct = 45;
				end
				1: begin
					snd_idle_pct = 45;
					rcv_idle_pct = 10;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			mix_start = items_sent;
			while (items_sent - mix_start < RAND_PER_MIX) begin
				if ($urandom_range(9) == 0) begin
					// Noise: any kind with any byte.
					repeat ($urandom_range(1, 8))
						send_plain(kind_t'($urandom_range(3)), 8'($urandom_range(255)));
				end else begin
					send_sequence();
				end
			end
		end
		in_valid <= 1'b0;

		while (match_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d items over three idle mixes; checked %0d match reports.",
			items_sent, results_seen);
		$display("Reports: %0d full matches, %0d store overflows, %0d leading stars.",
			full_matches, ovf_reports, star_reports);
		if (err_count == 0 && match_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d reports still pending", err_count, match_q.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/wspm_pkg.sv
sv/wspm_cell.sv
sv/wildcard_star_pattern_matcher_core.sv
bench/tb_wildcard_star_pattern_matcher_core.sv
